>>> hw/rtl/npnf_pkg.sv
// Shared types, constants and lookup tables for the nested pixel neighbour finder.
// No dependencies; imported by every module of the block.
package npnf_pkg;

	// Fixed field widths.
	localparam int PIX_W = 30;
	localparam int NB_W = 31;
	localparam int ORDER_W = 4;
	localparam int FACE_W = 4;
	localparam int ORIENT_W = 3;
	localparam int NB_COUNT = 8;
	localparam int MAX_ORDER_DEF = 13;

	// Number of base faces; a face number at or above this is out of range.
	localparam logic [PIX_W-1:0] NUM_FACES = PIX_W'(12);

	// Neighbour code for "no neighbour": all ones in 31 bits.
	localparam logic [NB_W-1:0] NB_NONE = {NB_W{1'b1}};

	// Face table code for a missing neighbour face.
	localparam logic [FACE_W-1:0] FACE_NONE = 4'd15;

	// Orientation bits.
	localparam int ORIENT_FLIP_X = 0;
	localparam int ORIENT_FLIP_Y = 1;
	localparam int ORIENT_SWAP = 2;

	// Offsets of the eight neighbours in output order SW, W, NW, N, NE, E, SE, S.
	localparam int OFF_X_TAB [NB_COUNT] = '{-1, -1, 0, 1, 1, 1, 0, -1};
	localparam int OFF_Y_TAB [NB_COUNT] = '{0, 1, 1, 1, 0, -1, -1, -1};

	// Neighbour face by direction code (rows) and base face (columns).
	localparam logic [FACE_W-1:0] FACE_TAB [9][12] = '{
		'{4'd8, 4'd9, 4'd10, 4'd11, 4'd15, 4'd15, 4'd15, 4'd15, 4'd10, 4'd11, 4'd8, 4'd9},
		'{4'd5, 4'd6, 4'd7, 4'd4, 4'd8, 4'd9, 4'd10, 4'd11, 4'd9, 4'd10, 4'd11, 4'd8},
		'{4'd15, 4'd15, 4'd15, 4'd15, 4'd5, 4'd6, 4'd7, 4'd4, 4'd15, 4'd15, 4'd15, 4'd15},
		'{4'd4, 4'd5, 4'd6, 4'd7, 4'd11, 4'd8, 4'd9, 4'd10, 4'd11, 4'd8, 4'd9, 4'd10},
		'{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11},
		'{4'd1, 4'd2, 4'd3, 4'd0, 4'd0, 4'd1, 4'd2, 4'd3, 4'd5, 4'd6, 4'd7, 4'd4},
		'{4'd15, 4'd15, 4'd15, 4'd15, 4'd7, 4'd4, 4'd5, 4'd6, 4'd15, 4'd15, 4'd15, 4'd15},
		'{4'd3, 4'd0, 4'd1, 4'd2, 4'd3, 4'd0, 4'd1, 4'd2, 4'd4, 4'd5, 4'd6, 4'd7},
		'{4'd2, 4'd3, 4'd0, 4'd1, 4'd15, 4'd15, 4'd15, 4'd15, 4'd0, 4'd1, 4'd2, 4'd3}
	};

	// Orientation bits by direction code (rows) and face row (columns).
	localparam logic [ORIENT_W-1:0] ORIENT_TAB [9][3] = '{
		'{3'd0, 3'd0, 3'd3}, '{3'd0, 3'd0, 3'd6}, '{3'd0, 3'd0, 3'd0},
		'{3'd0, 3'd0, 3'd5}, '{3'd0, 3'd0, 3'd0}, '{3'd5, 3'd0, 3'd0},
		'{3'd0, 3'd0, 3'd0}, '{3'd6, 3'd0, 3'd0}, '{3'd3, 3'd0, 3'd0}
	};

	// Control that travels alongside each beat in the pipeline.
	typedef struct packed {
		logic valid;
		logic err;
		logic [ORDER_W-1:0] order;
	} ctl_t;

	// Neighbour face lookup; out-of-range codes give no face.
	function automatic logic [FACE_W-1:0] face_lookup(input logic [3:0] dir,
		input logic [FACE_W-1:0] face);
		logic [FACE_W-1:0] r;
		r = FACE_NONE;
		if (dir <= 4'd8 && face <= 4'd11) begin
			r = FACE_TAB[dir][face];
		end
		return r;
	endfunction

	// Orientation lookup by direction code and face row.
	function automatic logic [ORIENT_W-1:0] orient_lookup(input logic [3:0] dir,
		input logic [1:0] row);
		logic [ORIENT_W-1:0] r;
		r = '0;
		if (dir <= 4'd8 && row <= 2'd2) begin
			r = ORIENT_TAB[dir][row];
		end
		return r;
	endfunction

endpackage

>>> hw/rtl/npnf_unpack.sv
// Index unpack stage: splits a pixel index into base face and x/y by deinterleaving.
// Depends on npnf_pkg.
module npnf_unpack #(
	parameter int XY_W = 13
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  npnf_pkg::ctl_t          ctl_s1,
	input  logic [npnf_pkg::PIX_W-1:0] pix_s1,
	output npnf_pkg::ctl_t          ctl_s2,
	output logic [npnf_pkg::FACE_W-1:0] face_s2,
	output logic [XY_W-1:0]         ix_s2,
	output logic [XY_W-1:0]         iy_s2
);
	import npnf_pkg::*;

	localparam int SUB_W = 2 * XY_W;

	logic [PIX_W-1:0] shr;
	logic [SUB_W:0]   sub_mask_full;
	logic [SUB_W-1:0] sub;
	logic [XY_W-1:0]  ix;
	logic [XY_W-1:0]  iy;
	logic             err;

	// Face is the index shifted down by twice the order; beyond twelve faces is an error.
	always_comb begin
		shr = pix_s1 >> {ctl_s1.order, 1'b0};
		err = (shr >= NUM_FACES);
		sub_mask_full = ((SUB_W+1)'(1) << {ctl_s1.order, 1'b0}) - (SUB_W+1)'(1);
		sub = pix_s1[SUB_W-1:0] & sub_mask_full[SUB_W-1:0];
	end

	// Even bits give x, odd bits give y.
	always_comb begin
		for (int i = 0; i < XY_W; i++) begin
			ix[i] = sub[2*i];
			iy[i] = sub[2*i+1];
		end
	end

	// Control register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else begin
			ctl_s2.valid <= ctl_s1.valid;
			ctl_s2.err <= err;
			ctl_s2.order <= ctl_s1.order;
		end
	end

	// Payload register.
	always_ff @(posedge clk) begin
		face_s2 <= shr[FACE_W-1:0];
		ix_s2 <= ix;
		iy_s2 <= iy;
	end

endmodule

>>> hw/rtl/npnf_lane.sv
// One neighbour direction: offset and wrap into the adjacent face, then re-interleave.
// Depends on npnf_pkg; instantiated once per direction by the top level.
module npnf_lane #(
	parameter int XY_W = 13,
	parameter int OFF_X = 0,
	parameter int OFF_Y = 0
) (
	input  logic                        clk,
	input  npnf_pkg::ctl_t              ctl_s2,
	input  logic [npnf_pkg::FACE_W-1:0] face_s2,
	input  logic [XY_W-1:0]             ix_s2,
	input  logic [XY_W-1:0]             iy_s2,
	output logic [npnf_pkg::NB_W-1:0]   nb_s4
);
	import npnf_pkg::*;

	logic [XY_W:0]         mask_full;
	logic [XY_W-1:0]       mask;
	logic                  unx, ovx, uny, ovy;
	logic [XY_W-1:0]       xw, yw, xf, yf;
	logic [3:0]            dir;
	logic [FACE_W-1:0]     f;
	logic [ORIENT_W-1:0]   bits;

	logic                  none_s3;
	logic [FACE_W-1:0]     f_s3;
	logic [XY_W-1:0]       x_s3;
	logic [XY_W-1:0]       y_s3;
	logic [ORDER_W-1:0]    order_s3;

	logic [NB_W-1:0]       spread;
	logic [NB_W-1:0]       v;

	// Offset the position, detect leaving the face and wrap modulo the side.
	always_comb begin
		mask_full = ((XY_W+1)'(1) << ctl_s2.order) - (XY_W+1)'(1);
		mask = mask_full[XY_W-1:0];
		unx = (OFF_X < 0) && (ix_s2 == '0);
		ovx = (OFF_X > 0) && (ix_s2 == mask);
		uny = (OFF_Y < 0) && (iy_s2 == '0);
		ovy = (OFF_Y > 0) && (iy_s2 == mask);
		if (OFF_X > 0) begin
			xw = (ix_s2 + XY_W'(1)) & mask;
		end else if (OFF_X < 0) begin
			xw = (ix_s2 - XY_W'(1)) & mask;
		end else begin
			xw = ix_s2;
		end
		if (OFF_Y > 0) begin
			yw = (iy_s2 + XY_W'(1)) & mask;
		end else if (OFF_Y < 0) begin
			yw = (iy_s2 - XY_W'(1)) & mask;
		end else begin
			yw = iy_s2;
		end
		dir = 4'd4 + (ovx ? 4'd1 : 4'd0) - (unx ? 4'd1 : 4'd0)
			+ (ovy ? 4'd3 : 4'd0) - (uny ? 4'd3 : 4'd0);
	end

	// Pick the neighbouring face and reorient the position into it.
	always_comb begin
		f = face_lookup(dir, face_s2);
		bits = orient_lookup(dir, face_s2[3:2]);
		xf = bits[ORIENT_FLIP_X] ? (xw ^ mask) : xw;
		yf = bits[ORIENT_FLIP_Y] ? (yw ^ mask) : yw;
	end

	// Stage 3 register.
	always_ff @(posedge clk) begin
		none_s3 <= ctl_s2.err || (f == FACE_NONE);
		f_s3 <= f;
		x_s3 <= bits[ORIENT_SWAP] ? yf : xf;
		y_s3 <= bits[ORIENT_SWAP] ? xf : yf;
		order_s3 <= ctl_s2.order;
	end

	// Interleave x and y and place the face above them.
	always_comb begin
		spread = '0;
		for (int i = 0; i < XY_W; i++) begin
			spread[2*i] = x_s3[i];
			spread[2*i+1] = y_s3[i];
		end
		v = (NB_W'(f_s3) << {order_s3, 1'b0}) | spread;
	end

	// Stage 4 register.
	always_ff @(posedge clk) begin
		nb_s4 <= none_s3 ? NB_NONE : v;
	end

endmodule

>>> hw/rtl/nested_pixel_neighbour_finder.sv
// Top level of the nested pixel neighbour finder: input stage, unpack and eight lanes.
// Depends on npnf_pkg, npnf_unpack and npnf_lane.
//
//  channel   ports                                      handshake
//  ------    -----                                      ---------
//  config    cfg_we, cfg_wdata                          write when cfg_we is high
//  input     start, busy, pixel_index                   taken when start && !busy
//  result    done, nb_sw .. nb_s, index_error           one cycle, marked by done
//
// One beat is taken every cycle; busy is always low. Four register stages (input register,
// unpack, offset and reorient, interleave) lie between the edge that takes a beat and the
// appearance of its result on the ports.
// Reset clears the order register and every valid bit; payload registers are not reset.
// The receiver cannot hold results off, so the pipeline never stalls.
module nested_pixel_neighbour_finder #(
	parameter int MAX_ORDER = npnf_pkg::MAX_ORDER_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [npnf_pkg::ORDER_W-1:0]     cfg_wdata,
	input  logic                             start,
	output logic                             busy,
	input  logic [npnf_pkg::PIX_W-1:0]       pixel_index,
	output logic                             done,
	output logic signed [npnf_pkg::NB_W-1:0] nb_sw,
	output logic signed [npnf_pkg::NB_W-1:0] nb_w,
	output logic signed [npnf_pkg::NB_W-1:0] nb_nw,
	output logic signed [npnf_pkg::NB_W-1:0] nb_n,
	output logic signed [npnf_pkg::NB_W-1:0] nb_ne,
	output logic signed [npnf_pkg::NB_W-1:0] nb_e,
	output logic signed [npnf_pkg::NB_W-1:0] nb_se,
	output logic signed [npnf_pkg::NB_W-1:0] nb_s,
	output logic                             index_error
);
	import npnf_pkg::*;

	localparam int XY_W = (MAX_ORDER > 0) ? MAX_ORDER : 1;
	localparam logic [ORDER_W-1:0] ORDER_CAP = ORDER_W'(MAX_ORDER);

	logic [ORDER_W-1:0] order_q;
	logic [ORDER_W-1:0] order_c;
	ctl_t               ctl_s1;
	ctl_t               ctl_s2;
	ctl_t               ctl_s3;
	ctl_t               ctl_s4;
	logic [PIX_W-1:0]   pix_s1;
	logic [FACE_W-1:0]  face_s2;
	logic [XY_W-1:0]    ix_s2;
	logic [XY_W-1:0]    iy_s2;
	logic [NB_W-1:0]    nb_s4 [NB_COUNT];

	// The pipeline has no back-pressure, so a beat is taken every cycle.
	assign busy = 1'b0;

	// Resolution order register, clamped to the largest supported order.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= '0;
		end else if (cfg_we) begin
			order_q <= cfg_wdata;
		end
	end

	assign order_c = (order_q > ORDER_CAP) ? ORDER_CAP : order_q;

	// Input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1.valid <= start && !busy;
			ctl_s1.err <= 1'b0;
			ctl_s1.order <= order_c;
		end
	end

	always_ff @(posedge clk) begin
		pix_s1 <= pixel_index;
	end

	// Unpack into face and position.
	npnf_unpack #(
		.XY_W(XY_W)
	) u_unpack (
		.clk(clk),
		.arst_n(arst_n),
		.ctl_s1(ctl_s1),
		.pix_s1(pix_s1),
		.ctl_s2(ctl_s2),
		.face_s2(face_s2),
		.ix_s2(ix_s2),
		.iy_s2(iy_s2)
	);

	// One lane per neighbour direction.
	for (genvar g = 0; g < NB_COUNT; g++) begin : g_lane
		npnf_lane #(
			.XY_W(XY_W),
			.OFF_X(OFF_X_TAB[g]),
			.OFF_Y(OFF_Y_TAB[g])
		) u_lane (
			.clk(clk),
			.ctl_s2(ctl_s2),
			.face_s2(face_s2),
			.ix_s2(ix_s2),
			.iy_s2(iy_s2),
			.nb_s4(nb_s4[g])
		);
	end

	// Control follows the lanes through stages three and four.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
			ctl_s4 <= '0;
		end else begin
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
		end
	end

	// Result ports.
	assign done = ctl_s4.valid;
	assign index_error = ctl_s4.err;
	assign nb_sw = nb_s4[0];
	assign nb_w = nb_s4[1];
	assign nb_nw = nb_s4[2];
	assign nb_n = nb_s4[3];
	assign nb_ne = nb_s4[4];
	assign nb_e = nb_s4[5];
	assign nb_se = nb_s4[6];
	assign nb_s = nb_s4[7];

endmodule
